// ----- hw/rtl/jtag_tst_pkg.sv -----
// ---------------------------------------------------------------------------
// jtag_tst_pkg
// Shared types, constants and the TAP next-state function for the JTAG
// TAP session tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package jtag_tst_pkg;

    typedef enum logic [3:0] {
        TAP_RESET      = 4'd0,
        TAP_IDLE       = 4'd1,
        TAP_SELECT_DR  = 4'd2,
        TAP_CAPTURE_DR = 4'd3,
        TAP_SHIFT_DR   = 4'd4,
        TAP_EXIT1_DR   = 4'd5,
        TAP_PAUSE_DR   = 4'd6,
        TAP_EXIT2_DR   = 4'd7,
        TAP_UPDATE_DR  = 4'd8,
        TAP_SELECT_IR  = 4'd9,
        TAP_CAPTURE_IR = 4'd10,
        TAP_SHIFT_IR   = 4'd11,
        TAP_EXIT1_IR   = 4'd12,
        TAP_PAUSE_IR   = 4'd13,
        TAP_EXIT2_IR   = 4'd14,
        TAP_UPDATE_IR  = 4'd15
    } t_tap_state;

    localparam int CMD_LEN_W = 15;
    localparam int TMS_BYTE_W = 8;
    localparam int IN_DATA_W = 24;   // tms + length + byte = 24, already byte aligned
    localparam int OUT_DATA_W = 8;   // state + ignored + done = 6, padded

    // Known spurious moves
    localparam logic [CMD_LEN_W-1:0]  SPUR_IR_LEN  = 15'd5;
    localparam logic [TMS_BYTE_W-1:0] SPUR_IR_BYTE = 8'h17;
    localparam logic [CMD_LEN_W-1:0]  SPUR_DR_LEN  = 15'd4;
    localparam logic [TMS_BYTE_W-1:0] SPUR_DR_BYTE = 8'h0b;

    function automatic t_tap_state tap_next(input t_tap_state cur, input logic tms);
        t_tap_state nxt;
        case (cur)
            TAP_RESET:      nxt = tms ? TAP_RESET     : TAP_IDLE;
            TAP_IDLE:       nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
            TAP_SELECT_DR:  nxt = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
            TAP_CAPTURE_DR: nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
            TAP_SHIFT_DR:   nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
            TAP_EXIT1_DR:   nxt = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
            TAP_PAUSE_DR:   nxt = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
            TAP_EXIT2_DR:   nxt = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
            TAP_UPDATE_DR:  nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
            TAP_SELECT_IR:  nxt = tms ? TAP_RESET     : TAP_CAPTURE_IR;
            TAP_CAPTURE_IR: nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
            TAP_SHIFT_IR:   nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
            TAP_EXIT1_IR:   nxt = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
            TAP_PAUSE_IR:   nxt = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
            TAP_EXIT2_IR:   nxt = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
            TAP_UPDATE_IR:  nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
            default:        nxt = TAP_RESET;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jtag_tap_session_tracker.sv -----
// Path: an accepted item is held in the input register, then in the result register, which drives m_axis.
// Throughput: one item per cycle while m_axis does not stall; the TAP state and flags
// update together with the result register, so consecutive bits follow back to back.
// Reset: synchronous, active low; clears the TAP state to test-logic-reset,
// both flags and the valid bits of the input and result registers.
// ---------------------------------------------------------------------------
// jtag_tap_session_tracker
// Follows the TAP controller from a stream of TMS bits, flags spurious
// commands and reports session end after reset-to-idle.
// ---------------------------------------------------------------------------
`default_nettype none

module jtag_tap_session_tracker
    import jtag_tst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [0] tms, [15:1] command_length, [23:16] first_tms_byte
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] first_of_command
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,   // last_of_command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] tap_state, [4] command_ignored, [5] session_done, [7:6] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // input register
    logic                  r_in_vld;
    logic                  r_in_tms;
    logic                  r_in_first;
    logic                  r_in_last;
    logic [CMD_LEN_W-1:0]  r_in_len;
    logic [TMS_BYTE_W-1:0] r_in_byte;

    // tracker state
    t_tap_state r_tap;
    logic       r_seen;
    logic       r_ign;

    // result register
    logic       r_out_vld;
    t_tap_state r_out_state;
    logic       r_out_ign;
    logic       r_out_done;

    logic       adv;
    t_tap_state n_tap;
    logic       n_seen;
    logic       n_ign;
    logic       seen_eff;
    logic       done;

    assign adv = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_comb begin
        seen_eff = r_seen;
        n_ign    = r_ign;
        if (r_in_first) begin
            seen_eff = (r_seen || r_tap == TAP_RESET)
                       && r_tap != TAP_CAPTURE_DR && r_tap != TAP_CAPTURE_IR;
            n_ign = (r_tap == TAP_EXIT1_IR && r_in_len == SPUR_IR_LEN
                     && r_in_byte == SPUR_IR_BYTE)
                 || (r_tap == TAP_EXIT1_DR && r_in_len == SPUR_DR_LEN
                     && r_in_byte == SPUR_DR_BYTE);
        end
        n_tap  = n_ign ? r_tap : tap_next(r_tap, r_in_tms);
        done   = r_in_last && seen_eff && n_tap == TAP_IDLE;
        n_seen = seen_eff && !done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tms   <= s_axis_tdata[0];
            r_in_len   <= s_axis_tdata[CMD_LEN_W:1];
            r_in_byte  <= s_axis_tdata[IN_DATA_W-1:CMD_LEN_W+1];
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap     <= TAP_RESET;
            r_seen    <= 1'b0;
            r_ign     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_tap  <= n_tap;
                r_seen <= n_seen;
                r_ign  <= n_ign;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (adv) begin
            r_out_state <= n_tap;
            r_out_ign   <= n_ign;
            r_out_done  <= done;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_done, r_out_ign, r_out_state};

    // session end only ever reported in run-test/idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_done) |-> r_out_state == TAP_IDLE)
        else $error("session_done outside idle");

    // an ignored bit leaves the TAP state where it was
    a_ign_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_ign) |=> r_tap == $past(r_tap))
        else $error("ignored bit moved TAP state");

    // reporting session end clears the reset-seen flag
    a_done_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && done) |=> !r_seen)
        else $error("reset-seen flag not cleared on session end");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives TMS bit streams, grouped into shift commands, into the TAP session
// tracker and checks every result item against a TAP state predictor or a typed result.
// A short table of directed bits comes first, then random commands.
// ---------------------------------------------------------------------------

module tb_top;
    import jtag_tst_pkg::*;

    localparam int N_RANDOM    = 2000;
    localparam int HOLD_AT     = 600;     // item count that triggers the long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_CYCLES  = 400000;
    localparam int N_DIRECTED  = 25;

    typedef struct packed {
        t_tap_state st;
        logic       ign;
        logic       done;
    } tap_out_t;

    typedef struct packed {
        logic                  tms;
        logic                  first;
        logic                  last;
        logic [CMD_LEN_W-1:0]  len;
        logic [TMS_BYTE_W-1:0] tbyte;
        logic                  chk;    // use the typed result below
        tap_out_t              want;
    } tms_bit_t;

    localparam tap_out_t DONT_CARE = '{TAP_RESET, 1'b0, 1'b0};

    localparam t_tap_state NEXT_ON_LOW [16] = '{
        TAP_IDLE, TAP_IDLE, TAP_CAPTURE_DR, TAP_SHIFT_DR, TAP_SHIFT_DR, TAP_PAUSE_DR,
        TAP_PAUSE_DR, TAP_SHIFT_DR, TAP_IDLE, TAP_CAPTURE_IR, TAP_SHIFT_IR,
        TAP_SHIFT_IR, TAP_PAUSE_IR, TAP_PAUSE_IR, TAP_SHIFT_IR, TAP_IDLE
    };
    localparam t_tap_state NEXT_ON_HIGH [16] = '{
        TAP_RESET, TAP_SELECT_DR, TAP_SELECT_IR, TAP_EXIT1_DR, TAP_EXIT1_DR,
        TAP_UPDATE_DR, TAP_EXIT2_DR, TAP_UPDATE_DR, TAP_SELECT_DR, TAP_RESET,
        TAP_EXIT1_IR, TAP_EXIT1_IR, TAP_UPDATE_IR, TAP_EXIT2_IR, TAP_UPDATE_IR,
        TAP_SELECT_DR
    };

    // tms, first, last, length, first byte, typed check, result
    localparam tms_bit_t DIRECTED_BITS [N_DIRECTED] = '{
        '{1'b1, 1'b0, 1'b0, 15'd0,     8'h00, 1'b1, '{TAP_RESET, 1'b0, 1'b0}},
        '{1'b0, 1'b1, 1'b1, 15'd1,     8'h00, 1'b1, '{TAP_IDLE, 1'b0, 1'b1}},
        '{1'b1, 1'b1, 1'b0, 15'd4,     8'h0b, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b0, 15'd4,     8'h0b, 1'b0, DONT_CARE},
        '{1'b0, 1'b0, 1'b0, 15'd4,     8'h0b, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b1, 15'd4,     8'h0b, 1'b0, DONT_CARE},
        '{1'b1, 1'b1, 1'b0, 15'd5,     8'h17, 1'b1, '{TAP_EXIT1_IR, 1'b1, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 15'd5,     8'h17, 1'b1, '{TAP_EXIT1_IR, 1'b1, 1'b0}},
        '{1'b1, 1'b0, 1'b1, 15'd5,     8'h17, 1'b1, '{TAP_EXIT1_IR, 1'b1, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 15'd5,     8'h16, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b0, 15'd5,     8'h16, 1'b0, DONT_CARE},
        '{1'b0, 1'b0, 1'b0, 15'd5,     8'h16, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b1, 15'd5,     8'h16, 1'b0, DONT_CARE},
        '{1'b0, 1'b1, 1'b0, 15'd4,     8'h0b, 1'b1, '{TAP_EXIT1_DR, 1'b1, 1'b0}},
        '{1'b1, 1'b0, 1'b1, 15'd4,     8'h0b, 1'b1, '{TAP_EXIT1_DR, 1'b1, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 15'h7fff,  8'hff, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b0, 15'h7fff,  8'hff, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b0, 15'h7fff,  8'hff, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b1, 15'h7fff,  8'hff, 1'b0, DONT_CARE},
        '{1'b0, 1'b1, 1'b0, 15'd16384, 8'h80, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b0, 15'd16384, 8'h80, 1'b0, DONT_CARE},
        '{1'b0, 1'b0, 1'b1, 15'd16384, 8'h80, 1'b0, DONT_CARE},
        // first bit in capture-dr drops the reset-seen flag
        '{1'b1, 1'b1, 1'b0, 15'd0,     8'h55, 1'b0, DONT_CARE},
        '{1'b1, 1'b0, 1'b0, 15'd0,     8'h55, 1'b0, DONT_CARE},
        '{1'b0, 1'b0, 1'b1, 15'd0,     8'h55, 1'b1, '{TAP_IDLE, 1'b0, 1'b0}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [0] tms, [15:1] command_length, [23:16] first_tms_byte
    logic                  s_axis_tuser;   // [0] first_of_command
    logic                  s_axis_tlast;   // last_of_command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [3:0] tap_state, [4] command_ignored,
                                           // [5] session_done, [7:6] zero

    // predictor state
    t_tap_state tap_now     = TAP_RESET;
    logic       reset_seen  = 1'b0;
    logic       spurious    = 1'b0;
    tap_out_t   tap_outcomes_q [$];

    int  err_count   = 0;
    int  cycles      = 0;
    int  n_sent      = 0;
    int  burst_left  = 0;
    bit  hold_req    = 1'b0;
    bit  rx_holding  = 1'b0;

    jtag_tap_session_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR cycle %0d: %s", cycles, msg);
    endtask

    // one TMS bit through the TAP controller and the session flags
    task automatic step_tap(input tms_bit_t b, output tap_out_t r);
        t_tap_state s;
        logic       ended;
        s = tap_now;
        ended = 1'b0;
        if (b.first) begin
            reset_seen = (reset_seen || s == TAP_RESET)
                         && s != TAP_CAPTURE_DR && s != TAP_CAPTURE_IR;
            spurious = (s == TAP_EXIT1_IR && b.len == SPUR_IR_LEN && b.tbyte == SPUR_IR_BYTE)
                    || (s == TAP_EXIT1_DR && b.len == SPUR_DR_LEN && b.tbyte == SPUR_DR_BYTE);
        end
        if (!spurious)
            s = b.tms ? NEXT_ON_HIGH[s] : NEXT_ON_LOW[s];
        tap_now = s;
        if (b.last && reset_seen && s == TAP_IDLE) begin
            ended = 1'b1;
            reset_seen = 1'b0;
        end
        r = '{s, spurious, ended};
    endtask

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_bit(input tms_bit_t b);
        tap_out_t r;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0 || rx_holding) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.tbyte, b.len, b.tms};
        s_axis_tuser  <= b.first;
        s_axis_tlast  <= b.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_tap(b, r);
        if (b.chk)
            r = b.want;
        tap_outcomes_q.push_back(r);
        n_sent++;
        if (n_sent == HOLD_AT)
            hold_req = 1'b1;
    endtask

    // one random shift command, steered toward the exit1 states and reset
    task automatic send_command();
        logic [15:0]           vec;
        int                    n;
        int                    kind;
        logic [CMD_LEN_W-1:0]  len_f;
        logic [TMS_BYTE_W-1:0] byte_f;
        bit                    drop_first;
        bit                    drop_last;
        tms_bit_t              b;
        kind = $urandom_range(0, 19);
        vec  = 16'($urandom);
        n    = $urandom_range(1, 10);
        if (kind == 19) begin
            // stray bits outside any command
            repeat ($urandom_range(1, 3)) begin
                b = '{1'($urandom), 1'b0, 1'b0, CMD_LEN_W'($urandom),
                      TMS_BYTE_W'($urandom), 1'b0, DONT_CARE};
                send_bit(b);
            end
            return;
        end
        if (tap_now == TAP_EXIT1_IR && kind < 12) begin
            n = 5;
            vec = 16'h0017;
        end else if (tap_now == TAP_EXIT1_DR && kind < 12) begin
            n = 4;
            vec = 16'h000b;
        end else if (kind < 3) begin
            n = 6;
            vec = 16'h001f;    // five ones to reset, then idle
        end else if (kind < 9 && tap_now == TAP_IDLE) begin
            if (kind[0]) begin
                n = 4;
                vec = 16'h000b;    // to exit1-ir
            end else begin
                n = 3;
                vec = 16'h0005;    // to exit1-dr
            end
        end else if (kind == 9) begin
            n = $urandom_range(11, 16);
        end
        len_f  = CMD_LEN_W'(n);
        byte_f = vec[7:0];
        if ($urandom_range(0, 15) == 0)
            len_f = CMD_LEN_W'($urandom_range(0, 32767));
        if ($urandom_range(0, 15) == 0)
            byte_f = TMS_BYTE_W'($urandom);
        drop_first = ($urandom_range(0, 24) == 0);
        drop_last  = ($urandom_range(0, 24) == 0);
        for (int i = 0; i < n; i++) begin
            b = '{vec[i], i == 0 && !drop_first, i == n - 1 && !drop_last,
                  len_f, byte_f, 1'b0, DONT_CARE};
            // length and byte only count on the first bit
            if (i != 0 && $urandom_range(0, 1)) begin
                b.len   = CMD_LEN_W'($urandom);
                b.tbyte = TMS_BYTE_W'($urandom);
            end
            send_bit(b);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
            send_bit(DIRECTED_BITS[i]);
        while (n_sent < N_DIRECTED + N_RANDOM)
            send_command();
        s_axis_tvalid <= 1'b0;
        while (tap_outcomes_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver: stall pattern changes every so often, plus one long hold-off
    initial begin
        int rx_mode;
        int rx_left;
        int rx_tick;
        rx_mode = 0;
        rx_left = 0;
        rx_tick = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            if (hold_req) begin
                hold_req = 1'b0;
                rx_holding = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_holding = 1'b0;
                m_axis_tready <= 1'b1;
            end else begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (rx_tick % 5) >= 2;
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        tap_out_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tap_outcomes_q.size() == 0) begin
                flag_error($sformatf("result 0x%02h with nothing expected", m_axis_tdata));
            end else begin
                w = tap_outcomes_q.pop_front();
                if (m_axis_tdata[3:0] != w.st)
                    flag_error($sformatf("tap_state got %0d want %0d (%s)",
                                         m_axis_tdata[3:0], w.st, w.st.name()));
                if (m_axis_tdata[4] != w.ign)
                    flag_error($sformatf("command_ignored got %0b want %0b",
                                         m_axis_tdata[4], w.ign));
                if (m_axis_tdata[5] != w.done)
                    flag_error($sformatf("session_done got %0b want %0b",
                                         m_axis_tdata[5], w.done));
            end
        end
    end

endmodule

// ----- jtag_tap_session_tracker.f -----
hw/rtl/jtag_tst_pkg.sv
hw/rtl/jtag_tap_session_tracker.sv
sim/tb_top.sv
